[rtl/b64d_pkg.sv]
package b64d_pkg;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_SYMBOL = 2'd1,
        ST_BAD_PAD    = 2'd2,
        ST_BAD_LENGTH = 2'd3
    } b64d_status_t;

    // Character codes that need special handling.
    localparam logic [7:0] CH_PAD   = 8'h3D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    // One input item.
    typedef struct packed {
        logic [7:0] char_in;
        logic       msg_end;
    } b64d_in_t;

    // One result item.
    typedef struct packed {
        logic [7:0]   byte_out;
        b64d_status_t status;
        logic         run_last;
        logic         msg_last;
    } b64d_out_t;

    // Work handed from the front part to the back part: all results of one item.
    typedef struct packed {
        logic [23:0]  data;
        logic [1:0]   cnt;
        b64d_status_t status;
        logic         msg_end;
    } b64d_job_t;

    // Decode one alphabet character. Bit 6 is set when the byte is not a data symbol.
    function automatic logic [6:0] sym_decode(input logic [7:0] c);
        logic [6:0] r;
        begin
            r = 7'h40;
            if (c inside {[8'h41:8'h5A]})
            begin
                r = {1'b0, 6'(c - 8'd65)};
            end
            else if (c inside {[8'h61:8'h7A]})
            begin
                r = {1'b0, 6'(c - 8'd71)};
            end
            else if (c inside {[8'h30:8'h39]})
            begin
                r = {1'b0, 6'(c + 8'd4)};
            end
            else if (c == CH_PLUS)
            begin
                r = {1'b0, 6'd62};
            end
            else if (c == CH_SLASH)
            begin
                r = {1'b0, 6'd63};
            end
            return r;
        end
    endfunction

endpackage

[rtl/b64d_front.sv]
module b64d_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  b64d_pkg::b64d_in_t item,
    output logic               job_push,
    output b64d_pkg::b64d_job_t job
);

    logic [23:0] acc_reg, acc_next;
    logic [1:0]  pos_reg, pos_next;
    logic [1:0]  pad_reg, pad_next;
    logic        disc_reg, disc_next;

    logic [6:0]  sym;
    logic [23:0] acc_shift;
    logic [1:0]  pad_inc;
    logic        job_valid;

    assign sym       = b64d_pkg::sym_decode(item.char_in);
    assign acc_shift = {acc_reg[17:0], 6'd0};
    assign pad_inc   = pad_reg + 2'd1;

    // Classify the character and work out the next quantum state and the job.
    always_comb
    begin
        acc_next    = acc_reg;
        pos_next    = pos_reg;
        pad_next    = pad_reg;
        disc_next   = disc_reg;
        job_valid   = 1'b0;
        job.data    = acc_shift;
        job.cnt     = 2'd1;
        job.status  = b64d_pkg::ST_OK;
        job.msg_end = item.msg_end;

        if (disc_reg)
        begin
            if (item.msg_end)
            begin
                disc_next = 1'b0;
            end
        end
        else if (item.msg_end && pos_reg != 2'd3)
        begin
            job_valid  = 1'b1;
            job.status = b64d_pkg::ST_BAD_LENGTH;
        end
        else if (pad_reg != 2'd0 && pos_reg == 2'd0)
        begin
            job_valid  = 1'b1;
            job.status = b64d_pkg::ST_BAD_PAD;
        end
        else if (item.char_in == b64d_pkg::CH_PAD)
        begin
            if (pos_reg < 2'd2)
            begin
                job_valid  = 1'b1;
                job.status = b64d_pkg::ST_BAD_PAD;
            end
            else if (pos_reg == 2'd2)
            begin
                acc_next = acc_shift;
                pad_next = 2'd1;
                pos_next = 2'd3;
            end
            else
            begin
                job_valid = 1'b1;
                job.cnt   = (pad_inc == 2'd1) ? 2'd2 : 2'd1;
                acc_next  = '0;
                pos_next  = 2'd0;
                pad_next  = item.msg_end ? 2'd0 : pad_inc;
            end
        end
        else if (pad_reg != 2'd0)
        begin
            job_valid  = 1'b1;
            job.status = b64d_pkg::ST_BAD_PAD;
        end
        else if (sym[6])
        begin
            job_valid  = 1'b1;
            job.status = b64d_pkg::ST_BAD_SYMBOL;
        end
        else if (pos_reg != 2'd3)
        begin
            acc_next = {acc_reg[17:0], sym[5:0]};
            pos_next = pos_reg + 2'd1;
        end
        else
        begin
            job_valid = 1'b1;
            job.data  = {acc_reg[17:0], sym[5:0]};
            job.cnt   = 2'd3;
            acc_next  = '0;
            pos_next  = 2'd0;
            pad_next  = 2'd0;
        end

        // Any error clears the quantum and drops the rest of the message.
        if (job_valid && job.status != b64d_pkg::ST_OK)
        begin
            job.data  = '0;
            job.cnt   = 2'd1;
            job.msg_end = 1'b1;
            acc_next  = '0;
            pos_next  = 2'd0;
            pad_next  = 2'd0;
            disc_next = !item.msg_end;
        end
    end

    assign job_push = accept && job_valid;

    // Quantum state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            pos_reg  <= 2'd0;
            pad_reg  <= 2'd0;
            disc_reg <= 1'b0;
        end
        else if (accept)
        begin
            acc_reg  <= acc_next;
            pos_reg  <= pos_next;
            pad_reg  <= pad_next;
            disc_reg <= disc_next;
        end
    end

    // An error always leaves a clean quantum behind it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (job_push && job.status != b64d_pkg::ST_OK) |=> (pos_reg == 2'd0 && pad_reg == 2'd0))
        else $error("quantum not cleared after error");

    // While characters are being dropped no job is produced.
    assert property (@(posedge clk) disable iff (!rst_n)
        disc_reg |-> !job_push)
        else $error("job produced while discarding");

    // Every job carries at least one result.
    assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> (job.cnt != 2'd0))
        else $error("job with no results");

endmodule

[rtl/b64d_queue.sv]
module b64d_queue #(
    parameter int DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  b64d_pkg::b64d_job_t push_job,
    input  logic                pop,
    output b64d_pkg::b64d_job_t head,
    output logic                q_empty,
    output logic                q_full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    b64d_pkg::b64d_job_t mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign q_empty = (count_reg == '0);
    assign q_full  = (count_reg == CW'(DEPTH));
    assign do_push = push && !q_full;
    assign do_pop  = pop && !q_empty;
    assign head    = mem_reg[rd_ptr_reg];

    // Pointer wrap and occupancy.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Job storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue occupancy out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(push && q_full))
        else $error("job pushed into a full queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && !do_push) |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("queue count did not drop after pop");

endmodule

[rtl/b64d_back.sv]
module b64d_back (
    input  logic                clk,
    input  logic                rst_n,
    input  b64d_pkg::b64d_job_t head,
    input  logic                q_empty,
    input  logic                pop,
    output logic                deq,
    output b64d_pkg::b64d_out_t result
);

    logic [1:0] k_reg, k_next;
    logic       last;

    assign last = (k_reg == head.cnt - 2'd1);

    // Pick the byte of the quantum that is due and mark the run ends.
    always_comb
    begin
        case (k_reg)
            2'd0:    result.byte_out = head.data[23:16];
            2'd1:    result.byte_out = head.data[15:8];
            2'd2:    result.byte_out = head.data[7:0];
            default: result.byte_out = 8'd0;
        endcase
        result.status   = head.status;
        result.run_last = last;
        result.msg_last = last && head.msg_end;
    end

    assign deq = pop && !q_empty && last;

    // Step through the bytes of the head job.
    always_comb
    begin
        k_next = k_reg;
        if (pop && !q_empty)
        begin
            k_next = last ? 2'd0 : k_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg <= 2'd0;
        end
        else
        begin
            k_reg <= k_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        !q_empty |-> (k_reg < head.cnt))
        else $error("byte index past end of job");

    assert property (@(posedge clk) disable iff (!rst_n)
        (!q_empty && head.status != b64d_pkg::ST_OK) |->
            (head.cnt == 2'd1 && result.byte_out == 8'd0 && result.msg_last))
        else $error("malformed error result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !q_empty && !last) |=> !q_empty)
        else $error("job left before all its bytes were taken");

endmodule

[rtl/base64_stream_decoder.sv]
// Streaming Base64 decoder (standard alphabet with '=' padding). One character
// is taken per cycle while full is low; full rises only when QUEUE_DEPTH
// decoded quanta or error reports are waiting to be read. Results leave one per
// cycle while empty is low: a complete quantum gives three bytes over three
// pops (two or one when padded), so four characters against three bytes keep
// pace with a steady one-character-per-cycle stream. A result is queued as the
// character ending its quantum is taken. Errors (bad symbol, bad padding, length
// not a multiple of four) give a single result with a zero byte and msg_last set;
// the rest of that message is then dropped without results.
module base64_stream_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  b64d_pkg::b64d_in_t  char_item,
    output logic                empty,
    input  logic                pop,
    output b64d_pkg::b64d_out_t result
);

    logic                job_push;
    b64d_pkg::b64d_job_t job;
    b64d_pkg::b64d_job_t head;
    logic                deq;
    logic                accept;

    assign accept = push && !full;

    // Front: classify characters and build quanta.
    b64d_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (char_item),
        .job_push (job_push),
        .job      (job)
    );

    // Queue of finished quanta and error reports.
    b64d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (job),
        .pop      (deq),
        .head     (head),
        .q_empty  (empty),
        .q_full   (full)
    );

    // Back: hand out the bytes one item at a time.
    b64d_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .q_empty (empty),
        .pop     (pop),
        .deq     (deq),
        .result  (result)
    );

endmodule
